// ----- sv/modexp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths, register map and controller/datapath interface types.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int ME_W     = 32;               // operand width
    localparam int ME_IDX_W = $clog2(ME_W);     // bit index width

    localparam logic [ME_W-1:0] ME_MOD_RESET = ME_W'(997);
    localparam logic [ME_W-1:0] ME_EXP_RESET = ME_W'(25);

    // register index, taken from paddr[2]
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    typedef struct packed {
        logic                load;      // capture operands, start item
        logic                red_step;  // one restoring-remainder step
        logic                mul_step;  // one step of both modular products
        logic                mul_first; // first step of a product, partials start at 0
        logic                mul_last;  // last step, commit products
        logic [ME_IDX_W-1:0] step_idx;  // bit of the serial operand
        logic [ME_IDX_W-1:0] bit_idx;   // exponent bit in use
        logic                finish;    // hand result to output register
    } t_cmd;

    typedef struct packed {
        logic cfg_mod_zero; // live modulus register is zero
        logic out_free;     // output register can take a word
    } t_stat;

endpackage : modexp_pkg
`default_nettype wire

// ----- sv/modexp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_ctrl
// Sequencer: base reduction, then per exponent bit one serial pass of the
// multiply and square units, then hand-off to the output register.
// ----------------------------------------------------------------------------
module modexp_ctrl
    import modexp_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RED  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    localparam logic [ME_IDX_W-1:0] IDX_TOP = ME_IDX_W'(ME_W - 1);

    logic [1:0]          r_state, n_state;
    logic [ME_IDX_W-1:0] r_step,  n_step;
    logic [ME_IDX_W-1:0] r_bit,   n_bit;
    logic                accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_cmd.step_idx  = r_step;
        o_cmd.bit_idx   = r_bit;
        o_cmd.mul_first = (r_step == IDX_TOP);
        o_cmd.mul_last  = (r_step == '0);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_step     = IDX_TOP;
                    n_bit      = '0;
                    n_state    = i_stat.cfg_mod_zero ? ST_FIN : ST_RED;
                end
            end
            ST_RED: begin
                o_cmd.red_step = 1'b1;
                if (r_step == '0) begin
                    n_step  = IDX_TOP;
                    n_state = ST_MUL;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_step == '0) begin
                    n_step = IDX_TOP;
                    if (r_bit == IDX_TOP) begin
                        n_state = ST_FIN;
                    end else begin
                        n_bit = r_bit + 1'b1;
                    end
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_bit   <= n_bit;
        end
    end

endmodule : modexp_ctrl
`default_nettype wire

// ----- sv/modexp_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_dp
// Datapath: bit-serial remainder for the base, and two shift/add modular
// multipliers (acc*b and b*b) that step together on the bits of b.
// ----------------------------------------------------------------------------
module modexp_dp
    import modexp_pkg::*;
(
    input  wire             i_clk,
    input  t_cmd            i_cmd,
    input  wire [ME_W-1:0]  i_modulus,
    input  wire [ME_W-1:0]  i_exponent,
    input  wire [ME_W-1:0]  i_base_value,
    output logic [ME_W-1:0] o_result,
    output logic            o_error
);

    logic [ME_W-1:0] r_m, r_e, r_base, r_b, r_acc, r_pa, r_pb;
    logic            r_err;
    logic [ME_W:0]   red_t;
    logic [ME_W-1:0] red_next;
    logic [ME_W-1:0] pa_in, pb_in, pa_dbl, pb_dbl, pa_next, pb_next;
    logic            mbit;

    // (a + b) mod m for a, b < m
    function automatic logic [ME_W-1:0] f_add_mod(input logic [ME_W-1:0] a,
                                                  input logic [ME_W-1:0] b,
                                                  input logic [ME_W-1:0] m);
        logic [ME_W-1:0] room;
        room = m - b;
        if (a >= room) begin
            return a - room;
        end
        return a + b;
    endfunction

    // restoring remainder step; r_b holds the partial remainder here
    assign red_t    = {r_b, r_base[i_cmd.step_idx]};
    assign red_next = (red_t >= {1'b0, r_m}) ? ME_W'(red_t - {1'b0, r_m})
                                             : red_t[ME_W-1:0];

    assign mbit    = r_b[i_cmd.step_idx];
    assign pa_in   = i_cmd.mul_first ? '0 : r_pa;
    assign pb_in   = i_cmd.mul_first ? '0 : r_pb;
    assign pa_dbl  = f_add_mod(pa_in, pa_in, r_m);
    assign pb_dbl  = f_add_mod(pb_in, pb_in, r_m);
    assign pa_next = mbit ? f_add_mod(pa_dbl, r_acc, r_m) : pa_dbl;
    assign pb_next = mbit ? f_add_mod(pb_dbl, r_b, r_m)   : pb_dbl;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m    <= i_modulus;
            r_e    <= i_exponent;
            r_base <= i_base_value;
            r_b    <= '0;
            r_err  <= (i_modulus == '0);
            // 1 mod m: zero when the modulus is one
            r_acc  <= (i_modulus == ME_W'(1)) ? '0 : ME_W'(1);
        end
        if (i_cmd.red_step) begin
            r_b <= red_next;
        end
        if (i_cmd.mul_step) begin
            r_pa <= pa_next;
            r_pb <= pb_next;
            if (i_cmd.mul_last) begin
                r_b <= pb_next;
                if (r_e[i_cmd.bit_idx]) begin
                    r_acc <= pa_next;
                end
            end
        end
    end

    // zero exponent gives 1 unreduced
    assign o_error  = r_err;
    assign o_result = r_err ? '0 : ((r_e == '0) ? ME_W'(1) : r_acc);

endmodule : modexp_dp
`default_nettype wire

// ----- sv/modular_exponentiation_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// base_value ^ exponent mod modulus, right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one base word; a word is taken
// when valid is high and stall is low. Output channel: o_out_valid /
// i_out_stall carry power_result and zero_modulus_error.
// modulus (addr 0) and exponent (addr 4) are set over the APB port; the user
// must set them only while idle, as the block itself has no check for it.
// Sequence: a load step, bit-serial base reduction, then for each exponent
// bit a serial pass of the paired modular multiply/square units, then the
// hand-off into the output register. The next word can be taken at the
// earliest edge at which the result of the last one can be taken. A zero
// modulus skips the arithmetic and returns 0 with the error flag.
// The input is stalled while a word is in progress. A finished result sits
// in the output register; the next word may be taken and computed meanwhile,
// and only its hand-off waits while the receiver stalls.
// Reset (synchronous, active low) restores modulus 997, exponent 25 and
// empties the pipeline.
// ----------------------------------------------------------------------------
module modular_exponentiation_core
    import modexp_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    // input channel
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire  [ME_W-1:0]  i_base_value,
    // output channel
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output logic [ME_W-1:0]  o_power_result,
    output logic             o_zero_modulus_error,
    // configuration
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire  [2:0]       paddr,
    input  wire  [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cmd            cmd;
    t_stat           stat;
    logic [ME_W-1:0] r_modulus, r_exponent;
    logic [ME_W-1:0] dp_result;
    logic            dp_error;
    logic            cfg_wr;
    logic            r_out_valid;
    logic [ME_W-1:0] r_power_result;
    logic            r_zero_modulus_error;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_EXPONENT) ? 32'(r_exponent) : 32'(r_modulus);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= ME_MOD_RESET;
            r_exponent <= ME_EXP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MODULUS) begin
                r_modulus <= ME_W'(pwdata);
            end else begin
                r_exponent <= ME_W'(pwdata);
            end
        end
    end

    assign stat.cfg_mod_zero = (r_modulus == '0);
    assign stat.out_free     = !r_out_valid || !i_out_stall;

    modexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    modexp_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_modulus    (r_modulus),
        .i_exponent   (r_exponent),
        .i_base_value (i_base_value),
        .o_result     (dp_result),
        .o_error      (dp_error)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.finish) begin
            r_power_result       <= dp_result;
            r_zero_modulus_error <= dp_error;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_power_result       = r_power_result;
    assign o_zero_modulus_error = r_zero_modulus_error;

endmodule : modular_exponentiation_core
`default_nettype wire

// ----- sv/modexp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_checker
// Port-level checks for modular_exponentiation_core, attached by bind.
// ----------------------------------------------------------------------------
module modexp_checker
    import modexp_pkg::*;
(
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_in_valid,
    input wire             o_in_stall,
    input wire             o_out_valid,
    input wire             i_out_stall,
    input wire [ME_W-1:0]  o_power_result,
    input wire             o_zero_modulus_error
);

    // one word at a time: input closes right after a word is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a word is in progress");

    // an error word always carries a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_modulus_error |-> o_power_result == '0)
        else $error("error word with nonzero result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_power_result)
            && $stable(o_zero_modulus_error))
        else $error("stalled output changed");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule : modexp_checker

bind modular_exponentiation_core modexp_checker u_modexp_checker (.*);
`default_nettype wire

// ----- tb/tb_modular_exponentiation_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_core
// Self-checking bench for the modular exponentiation core. Base words go in
// over the valid/stall channel, and each one is scored against a local
// square-and-multiply predictor that runs on the current modulus/exponent
// settings. Settings change over the APB port only while the core is drained.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_core;
    import modexp_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int TAIL_CYCLES  = 1100;     // idle tail before the final verdict
    localparam int HOLD_CYCLES  = 4000;     // long enough for input backpressure

    typedef struct packed {
        logic [ME_W-1:0] power;
        logic            err;
    } power_word_t;

    class modexp_scoreboard;
        logic [ME_W-1:0] modulus_q;
        logic [ME_W-1:0] exponent_q;
        power_word_t     pending_words[$];
        int              fail_count;

        function new();
            modulus_q  = ME_MOD_RESET;
            exponent_q = ME_EXP_RESET;
            fail_count = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == REG_MODULUS) begin
                modulus_q = val[ME_W-1:0];
            end else begin
                exponent_q = val[ME_W-1:0];
            end
        endfunction

        // operands stay below 2^32, so a 64-bit product never overflows
        function power_word_t modexp(logic [ME_W-1:0] base);
            logic [63:0] m;
            logic [63:0] sq;
            logic [63:0] acc;
            power_word_t w;
            int          i;
            m = 64'(modulus_q);
            if (m == 0) begin
                w.power = '0;
                w.err   = 1'b1;
                return w;
            end
            sq  = 64'(base) % m;
            acc = 64'd1;
            for (i = 0; i < ME_W; i++) begin
                if (exponent_q[i]) acc = (acc * sq) % m;
                sq = (sq * sq) % m;
            end
            // zero exponent gives 1 even for modulus 1
            if (exponent_q == 0) acc = 64'd1;
            w.power = acc[ME_W-1:0];
            w.err   = 1'b0;
            return w;
        endfunction

        function void note_base(logic [ME_W-1:0] base);
            pending_words.push_back(modexp(base));
        endfunction

        function void check_word(logic [ME_W-1:0] power, logic err);
            power_word_t want;
            if (pending_words.size() == 0) begin
                $error("unexpected word: power_result %0d, zero_modulus_error %0b",
                       power, err);
                fail_count++;
                return;
            end
            want = pending_words.pop_front();
            if (power !== want.power) begin
                $error("power_result: expected %0d, actual %0d", want.power, power);
                fail_count++;
            end
            if (err !== want.err) begin
                $error("zero_modulus_error: expected %0b, actual %0b", want.err, err);
                fail_count++;
            end
        endfunction

        function int outstanding();
            return pending_words.size();
        endfunction
    endclass

    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            in_valid     = 1'b0;
    logic [ME_W-1:0] base_value   = '0;
    logic            out_stall    = 1'b0;
    logic            psel         = 1'b0;
    logic            penable      = 1'b0;
    logic            pwrite       = 1'b0;
    logic [2:0]      paddr        = '0;
    logic [31:0]     pwdata       = '0;
    logic            hold_off_req = 1'b0;
    logic            calm_phase   = 1'b0;
    int              hold_left    = 0;
    int              cycle_count  = 0;

    wire             o_in_stall;
    wire             o_out_valid;
    wire [ME_W-1:0]  o_power_result;
    wire             o_zero_modulus_error;
    wire [31:0]      prdata;
    wire             pready;

    modexp_scoreboard sb = new();

    modular_exponentiation_core u_top (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (o_in_stall),
        .i_base_value         (base_value),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (out_stall),
        .o_power_result       (o_power_result),
        .o_zero_modulus_error (o_zero_modulus_error),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

    // result side: score accepted words, random stall, one long hold-off
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && o_out_valid && !out_stall) begin
                sb.check_word(o_power_result, o_zero_modulus_error);
            end
            if (hold_off_req) begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm_phase && ($urandom_range(99) < 13);
            end
        end
    end

    task automatic apb_write(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] mod_val, input logic [31:0] exp_val);
        apb_write(REG_MODULUS, mod_val);
        apb_write(REG_EXPONENT, exp_val);
    endtask

    task automatic send_base(input logic [ME_W-1:0] base);
        if (!calm_phase && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        base_value <= base;
        do @(posedge clk); while (o_in_stall);
        sb.note_base(base);
    endtask

    // sender stops until every outstanding word is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    function automatic logic [ME_W-1:0] pick_base(input logic [ME_W-1:0] m);
        case ($urandom_range(9))
            0:       return '0;
            1:       return m - 1'b1;
            2:       return m;
            3:       return '1;
            4:       return m * $urandom_range(7, 2);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input logic [31:0] mod_val, input logic [31:0] exp_val,
                             input int n_words);
        set_config(mod_val, exp_val);
        repeat (n_words) send_base(pick_base(mod_val[ME_W-1:0]));
        drain();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: modulus 997, exponent 25
        send_base(32'd0);
        send_base(32'd1);
        send_base(32'd2);
        send_base(32'd996);
        send_base(32'd997);
        send_base(32'd998);
        send_base(32'd1994);
        send_base(32'hFFFF_FFFF);
        send_base(32'h8000_0000);
        drain();

        // zero modulus wins over zero exponent
        set_config(32'd0, 32'd0);
        send_base(32'd0);
        send_base(32'hFFFF_FFFF);
        drain();

        // zero exponent with modulus 1 is still 1
        set_config(32'd1, 32'd0);
        send_base(32'd0);
        send_base(32'd7);
        drain();

        set_config(32'd1, 32'd5);
        send_base(32'd9);
        drain();

        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_base(32'hFFFF_FFFE);
        send_base(32'hFFFF_FFFF);
        send_base(32'd2);
        drain();

        set_config(32'hFFFF_FFFF, 32'd1);
        send_base(32'hFFFF_FFFF);
        send_base(32'd12345);
        drain();

        // receiver holds off while words keep coming, so the input backs up
        hold_off_req = 1'b1;
        run_phase($urandom, $urandom, 60);

        calm_phase = 1'b1;
        run_phase($urandom_range(1000, 2), $urandom, 40);
        calm_phase = 1'b0;

        run_phase(32'hFFFF_FFFF, $urandom, 30);
        run_phase(32'd0, $urandom, 15);
        run_phase(32'd1, $urandom, 15);
        run_phase($urandom, 32'd0, 15);
        run_phase($urandom, 32'hFFFF_FFFF, 25);
        run_phase($urandom | 32'h8000_0000, $urandom, 40);
        run_phase(32'h8000_0000, $urandom, 20);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.fail_count == 0 && sb.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/modexp_pkg.sv
sv/modexp_ctrl.sv
sv/modexp_dp.sv
sv/modular_exponentiation_core.sv
sv/modexp_checker.sv
tb/tb_modular_exponentiation_core.sv
